FILE: src/spa_pkg.sv
// Shared constants, action codes and the saturating add for the sparse polynomial adder.
// No dependencies; used by spa_prio, the top module, its checker and its testbench.
`default_nettype none

package spa_pkg;

    localparam int ExpW          = 10;   // exponent field
    localparam int CoefW         = 16;   // loaded coefficient
    localparam int SumW          = 32;   // stored / returned sum
    localparam int ActW          = 2;
    localparam int ExpSpan       = 1 << ExpW;
    localparam int MaxExpDefault = 1024;

    // Presence bits are kept 32 to a memory row.
    localparam int RowBits = 32;
    localparam int IdxW    = 5;

    localparam int InDataW  = 32;   // exponent + coefficient, padded to bytes
    localparam int OutDataW = 48;   // exponent + sum, padded to bytes

    localparam logic [ActW-1:0] ActLoad  = 2'd0;
    localparam logic [ActW-1:0] ActRead  = 2'd1;
    localparam logic [ActW-1:0] ActClear = 2'd2;

    function automatic logic [SumW-1:0] sat_add(input logic [SumW-1:0] a,
                                                input logic [CoefW-1:0] b);
        logic [SumW:0] s;
        s = {a[SumW-1], a} + {{(SumW-CoefW+1){b[CoefW-1]}}, b};
        if (s[SumW] != s[SumW-1]) begin
            sat_add = s[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
        end else begin
            sat_add = s[SumW-1:0];
        end
    endfunction

endpackage

`default_nettype wire

FILE: src/spa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module spa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic                                  i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: src/spa_prio.sv
// Highest-set-bit finder over one presence row, limited to bits at or below a given index.
// Depends on spa_pkg.
`default_nettype none

module spa_prio (
    input  wire logic [spa_pkg::RowBits-1:0] i_word,
    input  wire logic [spa_pkg::IdxW-1:0]    i_lim,
    output logic                             o_found,
    output logic      [spa_pkg::IdxW-1:0]    o_idx
);

    logic [spa_pkg::RowBits-1:0] masked;

    always_comb begin
        for (int i = 0; i < spa_pkg::RowBits; i++) begin
            masked[i] = i_word[i] && (spa_pkg::IdxW'(i) <= i_lim);
        end
    end

    // lowest index first, so the highest set bit wins
    always_comb begin
        o_found = 1'b0;
        o_idx   = '0;
        for (int i = 0; i < spa_pkg::RowBits; i++) begin
            if (masked[i]) begin
                o_found = 1'b1;
                o_idx   = spa_pkg::IdxW'(i);
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/sparse_polynomial_adder.sv
// Sparse polynomial adder. Load requests (tuser = 0) add a 16-bit signed coefficient into a
// 32-bit saturating sum held per exponent in a coefficient RAM; presence bits sit in a second
// RAM, 32 exponents to a row, with one valid flop per row so reset and a clear request
// (tuser = 2) empty the table by clearing those flops. Read requests (tuser = 1) return the
// next summed term, highest exponent first, with tlast on the lowest one and found (m_tuser)
// low once none remain. A load reads both RAMs, then writes back; a clear never leaves idle;
// a read scans presence rows downward from the previous hit, then fetches and emits the sum,
// or goes straight to emit when nothing is left. One request is in work at a time; a finished
// result waits in the output register while the next request is taken. Terms loaded above the
// current read point are not returned until the next clear.
// Depends on spa_pkg, spa_ram and spa_prio.
`default_nettype none

module sparse_polynomial_adder #(
    parameter int MAX_EXPONENTS = spa_pkg::MaxExpDefault
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [spa_pkg::InDataW-1:0]     s_tdata,   // [9:0] exponent, [25:10] coefficient
    input  wire logic [spa_pkg::ActW-1:0]        s_tuser,   // [1:0] action
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [spa_pkg::OutDataW-1:0]    m_tdata,   // [9:0] term_exponent, [41:10] term_coefficient
    output logic                                 m_tuser,   // [0] found
    output logic                                 m_tlast
);

    // exponents beyond the 10-bit field can never be loaded
    localparam int Emax  = (MAX_EXPONENTS < spa_pkg::ExpSpan) ? MAX_EXPONENTS : spa_pkg::ExpSpan;
    localparam int PW    = $clog2(Emax + 1);
    localparam int CAW   = $clog2(Emax);
    localparam int Rows  = (Emax + spa_pkg::RowBits - 1) / spa_pkg::RowBits;
    localparam int RW    = (Rows > 1) ? $clog2(Rows) : 1;
    localparam int RowHi = spa_pkg::ExpW - spa_pkg::IdxW;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_FETCH = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0]                    r_state, n_state;
    logic [PW-1:0]                 r_ptr, n_ptr;      // scan point
    logic [PW-1:0]                 r_rem, n_rem;      // present exponents below scan point
    logic [Rows-1:0]               r_row_vld, n_row_vld;
    logic [RW-1:0]                 r_row, n_row;
    logic [spa_pkg::IdxW-1:0]      r_lim, n_lim;
    logic [spa_pkg::ExpW-1:0]      r_exp;
    logic [spa_pkg::CoefW-1:0]     r_coef;
    logic [spa_pkg::ExpW-1:0]      r_res_exp;
    logic [spa_pkg::SumW-1:0]      r_res_coef;
    logic                          r_res_found, r_res_last;
    logic                          r_out_valid;
    logic [spa_pkg::ExpW-1:0]      r_out_exp;
    logic [spa_pkg::SumW-1:0]      r_out_coef;
    logic                          r_out_found, r_out_last;

    logic                          s_fire, exp_ok, out_free;
    logic [spa_pkg::ExpW-1:0]      in_exp, pm1, hit_exp;
    logic [spa_pkg::CoefW-1:0]     in_coef;
    logic [RowHi-1:0]              in_row5, pm1_row5;
    logic [spa_pkg::RowBits-1:0]   pres_rdata, row_word, pres_wdata;
    logic [spa_pkg::SumW-1:0]      coef_rdata, coef_wdata;
    logic                          pres_re, coef_re, ld_we, ld_bit;
    logic [RW-1:0]                 pres_raddr;
    logic [CAW-1:0]                coef_raddr;
    logic                          hit_found;
    logic [spa_pkg::IdxW-1:0]      hit_idx;

    assign s_fire   = s_tvalid && s_tready;
    assign s_tready = (r_state == S_IDLE);
    assign in_exp   = s_tdata[spa_pkg::ExpW-1:0];
    assign in_coef  = s_tdata[spa_pkg::ExpW +: spa_pkg::CoefW];
    assign exp_ok   = 11'(in_exp) < 11'(Emax);
    assign in_row5  = in_exp[spa_pkg::ExpW-1:spa_pkg::IdxW];
    assign pm1      = spa_pkg::ExpW'(r_ptr - PW'(1));
    assign pm1_row5 = pm1[spa_pkg::ExpW-1:spa_pkg::IdxW];
    assign out_free = !r_out_valid || m_tready;

    // a row never written since the last clear reads as empty
    assign row_word   = r_row_vld[r_row] ? pres_rdata : '0;
    assign ld_bit     = row_word[r_exp[spa_pkg::IdxW-1:0]];
    assign ld_we      = (r_state == S_LOAD);
    assign pres_wdata = row_word | (spa_pkg::RowBits'(1) << r_exp[spa_pkg::IdxW-1:0]);
    assign coef_wdata = ld_bit ? spa_pkg::sat_add(coef_rdata, r_coef)
                               : {{(spa_pkg::SumW-spa_pkg::CoefW){r_coef[spa_pkg::CoefW-1]}},
                                  r_coef};
    assign hit_exp    = spa_pkg::ExpW'({r_row, hit_idx});

    spa_prio u_prio (
        .i_word  (row_word),
        .i_lim   (r_lim),
        .o_found (hit_found),
        .o_idx   (hit_idx)
    );

    spa_ram #(.WIDTH(spa_pkg::RowBits), .DEPTH(Rows)) u_pres_ram (
        .i_clk   (i_clk),
        .i_we    (ld_we),
        .i_waddr (r_row),
        .i_wdata (pres_wdata),
        .i_re    (pres_re),
        .i_raddr (pres_raddr),
        .o_rdata (pres_rdata)
    );

    spa_ram #(.WIDTH(spa_pkg::SumW), .DEPTH(Emax)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (ld_we),
        .i_waddr (r_exp[CAW-1:0]),
        .i_wdata (coef_wdata),
        .i_re    (coef_re),
        .i_raddr (coef_raddr),
        .o_rdata (coef_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_ptr      = r_ptr;
        n_rem      = r_rem;
        n_row_vld  = r_row_vld;
        n_row      = r_row;
        n_lim      = r_lim;
        pres_re    = 1'b0;
        pres_raddr = in_row5[RW-1:0];
        coef_re    = 1'b0;
        coef_raddr = in_exp[CAW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    case (s_tuser)
                        spa_pkg::ActLoad: begin
                            if (exp_ok) begin
                                pres_re = 1'b1;
                                coef_re = 1'b1;
                                n_row   = in_row5[RW-1:0];
                                n_state = S_LOAD;
                            end
                        end
                        spa_pkg::ActRead: begin
                            if (r_rem == '0) begin
                                n_ptr   = '0;
                                n_state = S_EMIT;
                            end else begin
                                pres_re    = 1'b1;
                                pres_raddr = pm1_row5[RW-1:0];
                                n_row      = pm1_row5[RW-1:0];
                                n_lim      = pm1[spa_pkg::IdxW-1:0];
                                n_state    = S_SCAN;
                            end
                        end
                        spa_pkg::ActClear: begin
                            n_row_vld = '0;
                            n_ptr     = PW'(Emax);
                            n_rem     = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_LOAD: begin
                n_row_vld[r_row] = 1'b1;
                if (!ld_bit && (11'(r_exp) < 11'(r_ptr))) begin
                    n_rem = r_rem + PW'(1);
                end
                n_state = S_IDLE;
            end
            S_SCAN: begin
                if (hit_found) begin
                    coef_re    = 1'b1;
                    coef_raddr = hit_exp[CAW-1:0];
                    n_ptr      = PW'(hit_exp);
                    n_rem      = r_rem - PW'(1);
                    n_state    = S_FETCH;
                end else begin
                    pres_re    = 1'b1;
                    pres_raddr = r_row - RW'(1);
                    n_row      = r_row - RW'(1);
                    n_lim      = '1;
                end
            end
            S_FETCH: n_state = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ptr       <= PW'(Emax);
            r_rem       <= '0;
            r_row_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ptr     <= n_ptr;
            r_rem     <= n_rem;
            r_row_vld <= n_row_vld;
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_row <= n_row;
        r_lim <= n_lim;
        if (s_fire) begin
            r_exp  <= in_exp;
            r_coef <= in_coef;
        end
        if (r_state == S_IDLE) begin
            // miss result; overwritten by a hit on its way through S_FETCH
            r_res_exp   <= '0;
            r_res_coef  <= '0;
            r_res_found <= 1'b0;
            r_res_last  <= 1'b0;
        end else if (r_state == S_FETCH) begin
            r_res_exp   <= spa_pkg::ExpW'(r_ptr);
            r_res_coef  <= coef_rdata;
            r_res_found <= 1'b1;
            r_res_last  <= (r_rem == '0);
        end
        if (r_state == S_EMIT && out_free) begin
            r_out_exp   <= r_res_exp;
            r_out_coef  <= r_res_coef;
            r_out_found <= r_res_found;
            r_out_last  <= r_res_last;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {{(spa_pkg::OutDataW-spa_pkg::ExpW-spa_pkg::SumW){1'b0}},
                       r_out_coef, r_out_exp};
    assign m_tuser  = r_out_found;
    assign m_tlast  = r_out_last;

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tuser) |-> (r_out_exp == '0 && r_out_coef == '0 && !m_tlast))
        else $error("miss result carries nonzero fields");

    a_rem_le_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem <= r_ptr)
        else $error("remaining count above scan point");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && s_tuser == spa_pkg::ActClear) |=> (r_rem == '0 && r_row_vld == '0))
        else $error("clear did not empty the table");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && !hit_found) |-> (r_row != '0))
        else $error("scan ran below row zero");

endmodule

`default_nettype wire

FILE: dv/sparse_polynomial_adder_checker.sv
// Result checker for the sparse polynomial adder: watches both stream channels, keeps its own
// coefficient table and read point, and compares every returned term with the oldest one due.
// Depends on spa_pkg.

module sparse_polynomial_adder_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    input  logic                         i_s_tready,
    input  logic [spa_pkg::InDataW-1:0]  i_s_tdata,   // [9:0] exponent, [25:10] coefficient
    input  logic [spa_pkg::ActW-1:0]     i_s_tuser,   // [1:0] action
    input  logic                         i_m_tvalid,
    input  logic                         i_m_tready,
    input  logic [spa_pkg::OutDataW-1:0] i_m_tdata,   // [9:0] term_exponent, [41:10] term_coefficient
    input  logic                         i_m_tuser,   // [0] found
    input  logic                         i_m_tlast,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_found_count,
    output int                           o_empty_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     NumExp  = spa_pkg::MaxExpDefault;
    localparam longint SumMaxL = 64'sd2147483647;
    localparam longint SumMinL = -64'sd2147483648;

    typedef struct packed {
        logic [spa_pkg::ExpW-1:0] expo;
        logic [spa_pkg::SumW-1:0] coef;
        logic                     found;
        logic                     last;
    } t_summed_term;

    logic [spa_pkg::SumW-1:0] coef_sum [NumExp];
    bit                       term_present [NumExp];
    int                       read_point = NumExp;
    t_summed_term             terms_due [$];
    int                       errs = 0;
    int                       n_found = 0;
    int                       n_empty = 0;

    // Sums are left as they are; they are only looked at behind a presence bit.
    function automatic void empty_sums();
        foreach (term_present[e]) term_present[e] = 1'b0;
        read_point = NumExp;
    endfunction

    function automatic int highest_below(int limit);
        int e;
        e = (limit > NumExp) ? NumExp : limit;
        while (e > 0) begin
            e--;
            if (term_present[e]) return e;
        end
        return -1;
    endfunction

    function automatic logic [spa_pkg::SumW-1:0] clamped_add(
            logic [spa_pkg::SumW-1:0] acc, logic [spa_pkg::CoefW-1:0] addend);
        longint s;
        s = longint'($signed(acc)) + longint'($signed(addend));
        if (s > SumMaxL) return spa_pkg::SumW'(SumMaxL);
        if (s < SumMinL) return spa_pkg::SumW'(SumMinL);
        return spa_pkg::SumW'(s);
    endfunction

    always @(posedge i_clk) begin
        t_summed_term              want;
        logic [spa_pkg::ExpW-1:0]  got_exp;
        logic [spa_pkg::SumW-1:0]  got_coef;
        logic [spa_pkg::ExpW-1:0]  e;
        logic [spa_pkg::CoefW-1:0] c;
        int                        hit;

        if (!i_rst_n) begin
            empty_sums();
            terms_due.delete();
        end else begin
            // Results first: a result never belongs to a request taken at the same edge.
            if (i_m_tvalid && i_m_tready) begin
                got_exp  = i_m_tdata[spa_pkg::ExpW-1:0];
                got_coef = i_m_tdata[spa_pkg::ExpW+spa_pkg::SumW-1:spa_pkg::ExpW];
                if (terms_due.size() == 0) begin
                    $error("unexpected result: term_exponent %0d, term_coefficient %0d",
                           got_exp, $signed(got_coef));
                    errs++;
                end else begin
                    want = terms_due.pop_front();
                    if (got_exp !== want.expo) begin
                        $error("term_exponent: expected %0d, actual %0d", want.expo, got_exp);
                        errs++;
                    end
                    if (got_coef !== want.coef) begin
                        $error("term_coefficient: expected %0d, actual %0d",
                               $signed(want.coef), $signed(got_coef));
                        errs++;
                    end
                    if (i_m_tuser !== want.found) begin
                        $error("found: expected %0d, actual %0d", want.found, i_m_tuser);
                        errs++;
                    end
                    if (i_m_tlast !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, i_m_tlast);
                        errs++;
                    end
                    if (want.found) n_found++;
                    else n_empty++;
                end
            end

            if (i_s_tvalid && i_s_tready) begin
                e = i_s_tdata[spa_pkg::ExpW-1:0];
                c = i_s_tdata[spa_pkg::ExpW+spa_pkg::CoefW-1:spa_pkg::ExpW];
                case (i_s_tuser)
                    spa_pkg::ActLoad: begin
                        if (term_present[e]) begin
                            coef_sum[e] = clamped_add(coef_sum[e], c);
                        end else begin
                            term_present[e] = 1'b1;
                            coef_sum[e]     = {{(spa_pkg::SumW-spa_pkg::CoefW){c[spa_pkg::CoefW-1]}},
                                               c};
                        end
                    end
                    spa_pkg::ActRead: begin
                        hit = highest_below(read_point);
                        if (hit < 0) begin
                            read_point = 0;
                            terms_due.push_back('0);
                        end else begin
                            read_point = hit;
                            terms_due.push_back('{expo:  hit[spa_pkg::ExpW-1:0],
                                                  coef:  coef_sum[hit],
                                                  found: 1'b1,
                                                  last:  (highest_below(hit) < 0)});
                        end
                    end
                    spa_pkg::ActClear: empty_sums();
                    default: ;   // unused code: no effect
                endcase
            end
        end

        o_fail_count  <= errs;
        o_pending     <= terms_due.size();
        o_found_count <= n_found;
        o_empty_count <= n_empty;
    end

endmodule

FILE: dv/sparse_polynomial_adder_tb.sv
// Testbench top for the sparse polynomial adder: clock, reset, request stimulus, result-side
// back-pressure, idle watchdog and verdict. Depends on spa_pkg, the block and its checker.

module sparse_polynomial_adder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                       Period      = 10;
    localparam int                       NumExp      = spa_pkg::MaxExpDefault;
    localparam logic [spa_pkg::ActW-1:0] ActUnused   = 2'd3;
    localparam int                       RandomItems = 700;
    localparam int                       HoldCycles  = 400;
    localparam int                       IdleLimit   = 3000;
    localparam int                       DrainCycles = 50;

    logic                         i_clk    = 1'b0;
    logic                         i_rst_n  = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [spa_pkg::InDataW-1:0]  s_tdata  = '0;    // [9:0] exponent, [25:10] coefficient
    logic [spa_pkg::ActW-1:0]     s_tuser  = '0;    // [1:0] action
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [spa_pkg::OutDataW-1:0] m_tdata;          // [9:0] term_exponent, [41:10] term_coefficient
    logic                         m_tuser;          // [0] found
    logic                         m_tlast;

    int fail_count, pending, found_count, empty_count;
    int n_load = 0, n_read = 0, n_clear = 0, n_unused = 0, items = 0;
    int quiet = 0;
    bit steady_send = 1'b0;
    bit hold_req = 1'b0;

    always #(Period / 2) i_clk = ~i_clk;

    sparse_polynomial_adder dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    sparse_polynomial_adder_checker term_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .i_m_tlast     (m_tlast),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_found_count (found_count),
        .o_empty_count (empty_count)
    );

    // Ends the run if neither channel moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
        else quiet++;
        if (quiet >= IdleLimit) begin
            $display("sparse_polynomial_adder_tb: FAIL");
            $finish;
        end
    end

    // Result side: random ready with occasional stalls, plus one long hold on request.
    initial begin
        int stall_left;
        int ready_pct;
        int cyc;
        stall_left = 0;
        ready_pct  = 100;
        cyc        = 0;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HoldCycles) @(posedge i_clk);
            end else begin
                if (cyc % 256 == 0) begin
                    case ($urandom_range(0, 3))
                        0: ready_pct = 100;
                        1: ready_pct = 85;
                        2: ready_pct = 50;
                        default: ready_pct = 20;
                    endcase
                end
                if (stall_left == 0 && $urandom_range(0, 99) < 2)
                    stall_left = $urandom_range(10, 60);
                if (stall_left > 0) begin
                    stall_left--;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= ($urandom_range(0, 99) < ready_pct);
                end
                cyc++;
                @(posedge i_clk);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [spa_pkg::CoefW-1:0] pick_coef();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return '0;
            default: return spa_pkg::CoefW'($urandom);
        endcase
    endfunction

    task automatic send_req(input logic [spa_pkg::ActW-1:0] act,
                            input logic [spa_pkg::ExpW-1:0] expo,
                            input logic [spa_pkg::CoefW-1:0] coef);
        int gap;
        gap = steady_send ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{(spa_pkg::InDataW-spa_pkg::ExpW-spa_pkg::CoefW){1'b0}}, coef, expo};
        do @(posedge i_clk); while (!s_tready);
        case (act)
            spa_pkg::ActLoad:  n_load++;
            spa_pkg::ActRead:  n_read++;
            spa_pkg::ActClear: n_clear++;
            default:           n_unused++;
        endcase
        items++;
    endtask

    task automatic read_term();
        send_req(spa_pkg::ActRead, spa_pkg::ExpW'($urandom), spa_pkg::CoefW'($urandom));
    endtask

    task automatic bulk_load(input logic [spa_pkg::ExpW-1:0] expo,
                             input logic [spa_pkg::CoefW-1:0] coef, input int count);
        repeat (count) send_req(spa_pkg::ActLoad, expo, coef);
    endtask

    // One pass: optional clear, two polynomials over a window of exponents, then read-out.
    task automatic poly_round(input int idx);
        int lo, hi, n_terms, n_reads, distinct;
        bit broken;
        bit seen [NumExp];
        logic [spa_pkg::ExpW-1:0] used [$];
        logic [spa_pkg::ExpW-1:0] e;

        steady_send = ($urandom_range(0, 3) == 0);
        distinct    = 0;
        if ($urandom_range(0, 4) != 0)
            send_req(spa_pkg::ActClear, spa_pkg::ExpW'($urandom), spa_pkg::CoefW'($urandom));
        if ($urandom_range(0, 2) == 0) begin
            lo = 0;
            hi = NumExp - 1;
        end else begin
            lo = $urandom_range(0, NumExp - 8);
            hi = lo + $urandom_range(7, 96);
            if (hi > NumExp - 1) hi = NumExp - 1;
        end

        repeat (2) begin
            n_terms = $urandom_range(1, 10);
            repeat (n_terms) begin
                if (used.size() > 0 && $urandom_range(0, 3) == 0)
                    e = used[$urandom_range(0, used.size() - 1)];
                else
                    e = spa_pkg::ExpW'($urandom_range(lo, hi));
                if (!seen[e]) begin
                    seen[e] = 1'b1;
                    distinct++;
                end
                used.push_back(e);
                send_req(spa_pkg::ActLoad, e, pick_coef());
                if ($urandom_range(0, 19) == 0)
                    send_req(ActUnused, spa_pkg::ExpW'($urandom), spa_pkg::CoefW'($urandom));
            end
        end

        if (idx == 6) begin
            // long result-side hold while reads keep coming
            hold_req    = 1'b1;
            steady_send = 1'b1;
        end

        n_reads = distinct + $urandom_range(0, 1);
        broken  = ($urandom_range(0, 9) == 0);
        if (broken) begin
            repeat (n_reads / 2) read_term();
            // late loads: some land above the read point and stay hidden
            repeat (2)
                send_req(spa_pkg::ActLoad, spa_pkg::ExpW'($urandom_range(lo, hi)), pick_coef());
            if ($urandom_range(0, 1) == 0)
                send_req(spa_pkg::ActClear, spa_pkg::ExpW'($urandom), spa_pkg::CoefW'($urandom));
            repeat (n_reads - n_reads / 2) read_term();
        end else begin
            repeat (n_reads) read_term();
        end
    endtask

    initial begin
        int idx;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty read, field extremes, merge to zero, row edges, unused code.
        read_term();
        send_req(spa_pkg::ActLoad, 10'd0, 16'h8000);
        send_req(spa_pkg::ActLoad, 10'd1023, 16'h7FFF);
        send_req(spa_pkg::ActLoad, 10'd512, 16'h0000);
        send_req(spa_pkg::ActLoad, 10'd1023, 16'h8001);   // sums to zero, still returned
        send_req(spa_pkg::ActLoad, 10'd31, 16'h5555);
        send_req(spa_pkg::ActLoad, 10'd32, 16'hAAAA);
        send_req(ActUnused, 10'h3FF, 16'hFFFF);
        repeat (6) read_term();                           // five terms, then none left
        // loads below and above the read point after reading has begun
        send_req(spa_pkg::ActClear, 10'd0, 16'd0);
        send_req(spa_pkg::ActLoad, 10'd100, 16'd5);
        read_term();
        send_req(spa_pkg::ActLoad, 10'd50, 16'd7);
        read_term();
        send_req(spa_pkg::ActLoad, 10'd200, 16'd9);
        read_term();
        // clear in the middle of a read-out
        send_req(spa_pkg::ActLoad, 10'd10, 16'd1);
        send_req(spa_pkg::ActLoad, 10'd30, 16'd2);
        read_term();
        send_req(spa_pkg::ActClear, 10'd0, 16'd0);
        read_term();

        // Repeated loads on one exponent at both field limits, back to back.
        steady_send = 1'b1;
        send_req(spa_pkg::ActClear, 10'd0, 16'd0);
        bulk_load(10'd9, 16'h7FFF, 12);
        bulk_load(10'd9, 16'h8000, 1);
        bulk_load(10'd5, 16'h8000, 12);
        repeat (3) read_term();
        steady_send = 1'b0;

        items = 0;
        idx   = 0;
        while (items < RandomItems) begin
            poly_round(idx);
            idx++;
        end

        s_tvalid <= 1'b0;
        // the pending count is a registered output of the checker
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        $display("Requests: %0d loads, %0d reads, %0d clears, %0d with the unused code.",
                 n_load, n_read, n_clear, n_unused);
        $display("Results checked: %0d returned terms, %0d empty reads.",
                 found_count, empty_count);
        if (fail_count == 0 && pending == 0) begin
            $display("sparse_polynomial_adder_tb: PASS");
        end else begin
            $display("sparse_polynomial_adder_tb: FAIL");
        end
        $finish;
    end

endmodule
